// File: rtl/wsds_pkg.sv
package wsds_pkg;

    // result kinds, carried on m_tuser
    localparam logic [1:0] KindSample = 2'd0;
    localparam logic [1:0] KindHdr    = 2'd1;
    localparam logic [1:0] KindErr    = 2'd2;
    localparam logic [1:0] KindEnd    = 2'd3;

    // register map, indexed by paddr[2]
    localparam logic RegVolume = 1'b0;
    localparam logic RegTick   = 1'b1;

    localparam int AddrW    = 3;
    localparam int OutDataW = 112;

    localparam logic [7:0]  VolumeReset   = 8'd255;
    localparam logic [31:0] TickRateReset = 32'd2000000;
    localparam logic [31:0] MinFmtBytes   = 32'd12;
    localparam logic [31:0] MaxFmtBytes   = 32'd34;

    // tags, first file byte in the low lane
    localparam logic [31:0] TagRiff = 32'h4646_4952;
    localparam logic [31:0] TagWave = 32'h4556_4157;
    localparam logic [31:0] TagData = 32'h6174_6164;

    typedef struct packed {
        logic step;   // input beat accepted this edge
        logic sel;    // 0: first result slot, 1: second slot
    } cmd_t;

    typedef struct packed {
        logic [1:0] count;    // results produced by the last beat
        logic       div_busy;
    } stat_t;

    function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] i);
        logic [7:0] r;
        case (i)
            2'd0:    r = tag[7:0];
            2'd1:    r = tag[15:8];
            2'd2:    r = tag[23:16];
            default: r = tag[31:24];
        endcase
        return r;
    endfunction

endpackage

// File: rtl/wsds_ctrl.sv
module wsds_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  wsds_pkg::stat_t stat,
    output wsds_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_OUT0,
        S_OUT1
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT0) || (state_reg == S_OUT1);
    assign cmd.step = s_tvalid && s_tready;
    assign cmd.sel  = (state_reg == S_OUT1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.count == 2'd0)
                    state_next = S_IDLE;
                else if (!stat.div_busy)
                    state_next = S_OUT0;
            end
            S_OUT0:
            begin
                if (m_tready)
                    state_next = (stat.count == 2'd2) ? S_OUT1 : S_IDLE;
            end
            S_OUT1:
            begin
                if (m_tready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/wsds_dpath.sv
module wsds_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  wsds_pkg::cmd_t                    cmd,
    output wsds_pkg::stat_t                   stat,
    input  logic                              in_op,
    input  logic [7:0]                        in_byte,
    input  logic [7:0]                        att,
    input  logic [31:0]                       tick_rate,
    output logic [1:0]                        out_kind,
    output logic [wsds_pkg::OutDataW-1:0]     out_data
);

    typedef enum logic [3:0] {
        PH_RIFF,
        PH_RSIZE,
        PH_WAVE,
        PH_FMTHDR,
        PH_FMTBODY,
        PH_SKIPHDR,
        PH_SKIPBODY,
        PH_DATAHDR,
        PH_PCM,
        PH_DONE,
        PH_ERR
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [5:0]  fbi_reg, fbi_next;
    logic [31:0] len_reg, len_next;
    logic [15:0] fmt_reg, fmt_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] played_reg, played_next;
    logic [7:0]  low_reg, low_next;
    logic [1:0]  count_reg, count_next;
    logic [1:0]  kind0_reg, kind0_next;
    logic [11:0] dac_reg, dac_next;

    logic [5:0]  div_cnt_reg;
    logic [31:0] div_r_reg;
    logic [31:0] div_q_reg;
    logic        div_start;
    logic [32:0] div_t;
    logic        div_ge;

    logic [31:0] len_add;
    logic [31:0] len_dec;
    logic [31:0] played_inc;
    logic [11:0] sample_val;
    logic [19:0] sample_prod;

    // chunk size bytes arrive little-endian at header indexes 4..7
    always_comb
    begin
        case (fbi_reg[1:0])
            2'd0:    len_add = {24'd0, in_byte};
            2'd1:    len_add = {len_reg[31:16], in_byte, len_reg[7:0]};
            2'd2:    len_add = {len_reg[31:24], in_byte, len_reg[15:0]};
            default: len_add = {in_byte, len_reg[23:0]};
        endcase
    end

    assign len_dec     = len_reg - 32'd1;
    assign played_inc  = played_reg + 32'd1;
    // offset binary: flip the sign, keep the top 12 bits
    assign sample_val  = {~in_byte[7], in_byte[6:0], low_reg[7:4]};
    assign sample_prod = sample_val * att;

    always_comb
    begin
        phase_next  = phase_reg;
        fbi_next    = fbi_reg;
        len_next    = len_reg;
        fmt_next    = fmt_reg;
        chan_next   = chan_reg;
        rate_next   = rate_reg;
        total_next  = total_reg;
        played_next = played_reg;
        low_next    = low_reg;
        count_next  = count_reg;
        kind0_next  = kind0_reg;
        dac_next    = dac_reg;
        div_start   = 1'b0;
        if (cmd.step)
        begin
            count_next = 2'd0;
            kind0_next = wsds_pkg::KindEnd;
            dac_next   = 12'd0;
            if (in_op)
            begin
                phase_next  = PH_RIFF;
                fbi_next    = 6'd0;
                len_next    = 32'd0;
                fmt_next    = 16'd0;
                chan_next   = 16'd0;
                rate_next   = 32'd0;
                total_next  = 32'd0;
                played_next = 32'd0;
                low_next    = 8'd0;
            end
            else
            begin
                case (phase_reg)
                    PH_RIFF, PH_WAVE:
                    begin
                        if (in_byte != wsds_pkg::tag_byte(
                                (phase_reg == PH_RIFF) ? wsds_pkg::TagRiff : wsds_pkg::TagWave,
                                fbi_reg[1:0]))
                        begin
                            phase_next = PH_ERR;
                            fbi_next   = 6'd0;
                            count_next = 2'd1;
                            kind0_next = wsds_pkg::KindErr;
                        end
                        else if (fbi_reg[1:0] == 2'd3)
                        begin
                            fbi_next   = 6'd0;
                            phase_next = (phase_reg == PH_RIFF) ? PH_RSIZE : PH_FMTHDR;
                        end
                        else
                            fbi_next = fbi_reg + 6'd1;
                    end
                    PH_RSIZE:
                    begin
                        if (fbi_reg[1:0] == 2'd3)
                        begin
                            fbi_next   = 6'd0;
                            phase_next = PH_WAVE;
                        end
                        else
                            fbi_next = fbi_reg + 6'd1;
                    end
                    PH_FMTHDR:
                    begin
                        if (fbi_reg[2])
                            len_next = len_add;
                        if (fbi_reg[2:0] == 3'd7)
                        begin
                            fbi_next = 6'd0;
                            if (len_add < wsds_pkg::MinFmtBytes || len_add > wsds_pkg::MaxFmtBytes)
                            begin
                                phase_next = PH_ERR;
                                count_next = 2'd1;
                                kind0_next = wsds_pkg::KindErr;
                            end
                            else
                            begin
                                fmt_next   = 16'd0;
                                chan_next  = 16'd0;
                                rate_next  = 32'd0;
                                phase_next = PH_FMTBODY;
                            end
                        end
                        else
                            fbi_next = fbi_reg + 6'd1;
                    end
                    PH_FMTBODY:
                    begin
                        if (fbi_reg < 6'd2)
                            fmt_next[8*fbi_reg[0] +: 8] = fmt_reg[8*fbi_reg[0] +: 8] | in_byte;
                        else if (fbi_reg < 6'd4)
                            chan_next[8*fbi_reg[0] +: 8] = chan_reg[8*fbi_reg[0] +: 8] | in_byte;
                        else if (fbi_reg < 6'd8)
                            rate_next[8*fbi_reg[1:0] +: 8] = rate_reg[8*fbi_reg[1:0] +: 8] | in_byte;
                        if (fbi_reg != 6'd63)
                            fbi_next = fbi_reg + 6'd1;
                        len_next = len_dec;
                        if (len_dec == 32'd0)
                        begin
                            fbi_next = 6'd0;
                            if (rate_next == 32'd0)
                            begin
                                phase_next = PH_ERR;
                                count_next = 2'd1;
                                kind0_next = wsds_pkg::KindErr;
                            end
                            else
                                phase_next = PH_SKIPHDR;
                        end
                    end
                    PH_SKIPHDR:
                    begin
                        if (fbi_reg[2])
                            len_next = len_add;
                        if (fbi_reg[2:0] == 3'd7)
                        begin
                            fbi_next   = 6'd0;
                            phase_next = (len_add == 32'd0) ? PH_DATAHDR : PH_SKIPBODY;
                        end
                        else
                            fbi_next = fbi_reg + 6'd1;
                    end
                    PH_SKIPBODY:
                    begin
                        len_next = len_dec;
                        if (len_dec == 32'd0)
                        begin
                            fbi_next   = 6'd0;
                            phase_next = PH_DATAHDR;
                        end
                    end
                    PH_DATAHDR:
                    begin
                        if (!fbi_reg[2] &&
                            in_byte != wsds_pkg::tag_byte(wsds_pkg::TagData, fbi_reg[1:0]))
                        begin
                            phase_next = PH_ERR;
                            fbi_next   = 6'd0;
                            count_next = 2'd1;
                            kind0_next = wsds_pkg::KindErr;
                        end
                        else
                        begin
                            if (fbi_reg[2])
                                len_next = len_add;
                            if (fbi_reg[2:0] == 3'd7)
                            begin
                                fbi_next    = 6'd0;
                                total_next  = len_add;
                                played_next = 32'd0;
                                phase_next  = PH_PCM;
                                count_next  = 2'd1;
                                kind0_next  = wsds_pkg::KindHdr;
                                div_start   = 1'b1;
                                if (len_add == 32'd0)
                                begin
                                    phase_next = PH_DONE;
                                    count_next = 2'd2;
                                end
                            end
                            else
                                fbi_next = fbi_reg + 6'd1;
                        end
                    end
                    PH_PCM:
                    begin
                        if (!played_reg[0])
                            low_next = in_byte;
                        else
                        begin
                            count_next = 2'd1;
                            kind0_next = wsds_pkg::KindSample;
                            dac_next   = sample_prod[19:8];
                        end
                        played_next = played_inc;
                        if (played_inc == total_reg)
                        begin
                            phase_next = PH_DONE;
                            // end mark follows the sample when one was made
                            if (played_reg[0])
                                count_next = 2'd2;
                            else
                            begin
                                count_next = 2'd1;
                                kind0_next = wsds_pkg::KindEnd;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_RIFF;
            fbi_reg    <= 6'd0;
            len_reg    <= 32'd0;
            fmt_reg    <= 16'd0;
            chan_reg   <= 16'd0;
            rate_reg   <= 32'd0;
            total_reg  <= 32'd0;
            played_reg <= 32'd0;
            low_reg    <= 8'd0;
            count_reg  <= 2'd0;
            kind0_reg  <= wsds_pkg::KindEnd;
            dac_reg    <= 12'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            fbi_reg    <= fbi_next;
            len_reg    <= len_next;
            fmt_reg    <= fmt_next;
            chan_reg   <= chan_next;
            rate_reg   <= rate_next;
            total_reg  <= total_next;
            played_reg <= played_next;
            low_reg    <= low_next;
            count_reg  <= count_next;
            kind0_reg  <= kind0_next;
            dac_reg    <= dac_next;
        end
    end

    // restoring divider, one quotient bit per cycle: tick_rate / rate
    assign div_t  = {div_r_reg, div_q_reg[31]};
    assign div_ge = (div_t >= {1'b0, rate_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= 6'd0;
        else if (div_start)
            div_cnt_reg <= 6'd32;
        else if (div_cnt_reg != 6'd0)
            div_cnt_reg <= div_cnt_reg - 6'd1;
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            div_r_reg <= 32'd0;
            div_q_reg <= tick_rate;
        end
        else if (div_cnt_reg != 6'd0)
        begin
            div_r_reg <= div_ge ? 32'(div_t - {1'b0, rate_reg}) : div_t[31:0];
            div_q_reg <= {div_q_reg[30:0], div_ge};
        end
    end

    assign stat.count    = count_reg;
    assign stat.div_busy = (div_cnt_reg != 6'd0);

    assign out_kind = cmd.sel ? wsds_pkg::KindEnd : kind0_reg;

    always_comb
    begin
        out_data = '0;
        if (!cmd.sel)
        begin
            out_data[11:0] = dac_reg;
            if (kind0_reg == wsds_pkg::KindHdr)
            begin
                out_data[43:12]  = rate_reg;
                out_data[59:44]  = chan_reg;
                out_data[75:60]  = fmt_reg;
                out_data[107:76] = div_q_reg;
            end
        end
    end

endmodule

// File: rtl/wav_stream_to_dac_samples_core.sv
// WAV byte stream to 12-bit DAC samples.
// Input channel s_*: one file byte per beat in s_tdata; s_tuser high restarts
// parsing for a new file (the byte is ignored). Output channel m_*: one result
// per beat, its kind on m_tuser (sample, header accepted, header error, end of
// data); header fields and timer period are valid only with a header result.
// APB port: volume at 0x0, tick_rate at 0x4, to be written only while idle;
// the block itself does not enforce this. One byte at a time: a beat is
// taken, the next cycle decides how many results it made (0 to 2), then
// each result is held on m_* until taken. The byte that completes the data
// chunk header also runs the period divider, one quotient bit per cycle,
// and its results wait until the divider is done. While the receiver
// stalls, s_tready stays low. Reset returns the parser to waiting for the
// RIFF tag, volume to 255 and tick_rate to 2000000; no results are pending
// after reset.
module wav_stream_to_dac_samples_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // [7:0] data_byte
    input  logic                                s_tuser,  // [0] op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [11:0] dac_sample, [43:12] sample_rate, [59:44] channel_count,
    // [75:60] format_code, [107:76] timer_period, [111:108] zero
    output logic [wsds_pkg::OutDataW-1:0]       m_tdata,
    output logic [1:0]                          m_tuser,  // [1:0] kind
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wsds_pkg::AddrW-1:0]          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [7:0]      volume_reg;
    logic [7:0]      att_reg;
    logic [31:0]     tick_reg;
    logic [15:0]     vol_sq;
    logic            cfg_wr;
    wsds_pkg::cmd_t  cmd;
    wsds_pkg::stat_t stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign vol_sq = pwdata[7:0] * pwdata[7:0];
    assign prdata = (paddr[2] == wsds_pkg::RegTick) ? tick_reg : {24'd0, volume_reg};

    // attenuation (v*v)>>8 is kept alongside the volume
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg <= wsds_pkg::VolumeReset;
            att_reg    <= 8'd254;
            tick_reg   <= wsds_pkg::TickRateReset;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == wsds_pkg::RegVolume)
            begin
                volume_reg <= pwdata[7:0];
                att_reg    <= vol_sq[15:8];
            end
            else
                tick_reg <= pwdata;
        end
    end

    wsds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wsds_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_op     (s_tuser),
        .in_byte   (s_tdata),
        .att       (att_reg),
        .tick_rate (tick_reg),
        .out_kind  (m_tuser),
        .out_data  (m_tdata)
    );

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result is pending");

    a_hdr_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != wsds_pkg::KindHdr) |-> (m_tdata[111:12] == '0))
        else $error("header fields on a non-header result");

    a_dac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != wsds_pkg::KindSample) |-> (m_tdata[11:0] == 12'd0))
        else $error("sample value on a non-sample result");

endmodule
